@@ sv/loop_branch_predictor_macros.svh @@
// ----------------------------------------------------------------------------
// Loop branch predictor assertion macros
// Concurrent assertion wrappers shared by the predictor RTL.
// ----------------------------------------------------------------------------
`ifndef LOOP_BRANCH_PREDICTOR_MACROS_SVH
`define LOOP_BRANCH_PREDICTOR_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge, ignored while reset is high.
`define LBP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define LBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LBP_ASSERT(lbl, clk, rst, prop, msg)
`define LBP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ sv/lbp_pkg.sv @@
// ----------------------------------------------------------------------------
// Loop branch predictor package
// Request and response word types, action codes and fixed constants.
// ----------------------------------------------------------------------------
package lbp_pkg;

  // Fixed field widths of the request word
  localparam int TAG_W   = 14;
  localparam int INDEX_W = 8;

  // Confidence saturation limit
  localparam logic [1:0] CONF_MAX = 2'd3;

  // Request action codes
  localparam logic ACT_PREDICT = 1'b0;
  localparam logic ACT_RESOLVE = 1'b1;

  typedef struct packed {
    logic               action;
    logic [INDEX_W-1:0] table_index;
    logic [TAG_W-1:0]   branch_tag;
    logic               fallback_taken;
    logic               outcome_taken;
  } req_word_t;

  typedef struct packed {
    logic predict_taken;
    logic loop_used;
  } rsp_word_t;

endpackage

@@ sv/loop_branch_predictor.sv @@
// ----------------------------------------------------------------------------
// Loop branch predictor
// Direct-mapped loop table with predict and resolve requests.
// ----------------------------------------------------------------------------
// Each request word first reads its table entry from the single-port-read
// RAM, then evaluates it and either loads the response register (predict) or
// writes back the trained entry, or a fresh one for a missed, mispredicted
// branch (resolve). A new word is accepted only once the last one is through.
// A predict waits in evaluation while the response register still holds an
// untaken word. After reset a clearing pass writes every entry to zero, during
// which no request is accepted. A resolve trains the entry chosen by the most
// recent predict; only a predict produces a response word.
// ----------------------------------------------------------------------------
`include "loop_branch_predictor_macros.svh"

module loop_branch_predictor #(
  parameter int TABLE_ENTRIES = 256,
  parameter int TAG_BITS      = 14,
  parameter int ITER_BITS     = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  lbp_pkg::req_word_t req_data,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output lbp_pkg::rsp_word_t rsp_data
);

  import lbp_pkg::*;

  localparam int IDX_W     = $clog2(TABLE_ENTRIES);
  localparam int IN_IDX_CT = 2 ** INDEX_W;

  typedef struct packed {
    logic                 valid;
    logic [TAG_BITS-1:0]  tag;
    logic [1:0]           conf;
    logic [ITER_BITS-1:0] trip;
    logic [ITER_BITS-1:0] iter;
    logic                 body;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t               state, state_next;
  logic [IDX_W-1:0]     clr_addr;
  logic [IDX_W-1:0]     saved_index;
  logic                 saved_fallback;
  logic                 cur_action;
  logic [TAG_W-1:0]     cur_tag;
  logic                 cur_outcome;

  logic                 accept;
  logic [IDX_W-1:0]     idx_lut [IN_IDX_CT];
  logic [IDX_W-1:0]     idx_pred;
  logic [TAG_BITS-1:0]  tag_cmp;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  entry_t               ram_wdata;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  entry_t               ent;

  logic                 hit;
  logic                 same;
  logic [ITER_BITS-1:0] iter_inc;
  logic [ITER_BITS-1:0] trip_dec;
  logic [1:0]           conf_dec;
  entry_t               trained;
  entry_t               alloc;
  logic                 rsv_write;
  logic                 out_free;
  logic                 pred_use;
  logic                 pred_dir;
  logic                 exec_done;

  // Reduce the request index modulo the table size
  for (genvar g = 0; g < IN_IDX_CT; g++) begin : g_idx_lut
    assign idx_lut[g] = IDX_W'(g % TABLE_ENTRIES);
  end
  assign idx_pred = idx_lut[req_data.table_index];

  // Keep the low TAG_BITS of the request tag, zero-extend if wider
  if (TAG_BITS <= TAG_W) begin : g_tag_trim
    assign tag_cmp = cur_tag[TAG_BITS-1:0];
  end else begin : g_tag_ext
    assign tag_cmp = {{(TAG_BITS-TAG_W){1'b0}}, cur_tag};
  end

  // Entry table
  lbp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ent)
  );

  // Handshake and read issue
  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign ram_re    = accept;
  assign ram_raddr = (req_data.action == ACT_PREDICT) ? idx_pred : saved_index;

  // Evaluate the entry read for the current word
  assign hit      = ent.valid && (ent.tag == tag_cmp);
  assign same     = (cur_outcome == ent.body);
  assign iter_inc = ent.iter + ITER_BITS'(1);
  assign trip_dec = ent.trip - ITER_BITS'(1);
  assign conf_dec = (ent.conf == 2'd0) ? 2'd0 : ent.conf - 2'd1;

  // Train a hitting entry with the resolved direction
  always_comb begin
    trained = ent;
    if (ent.conf != CONF_MAX) begin
      if (!same) begin
        if (ent.iter == ent.trip) begin
          trained.conf = ent.conf + 2'd1;
        end else begin
          trained.trip = iter_inc;
          trained.conf = conf_dec;
          if (conf_dec == 2'd0) begin
            trained.valid = 1'b0;
          end
        end
        trained.iter = '0;
      end else begin
        trained.iter = iter_inc;
        if (iter_inc > ent.trip) begin
          trained.trip = '0;
          trained.conf = conf_dec;
          if (conf_dec == 2'd0) begin
            trained.valid = 1'b0;
          end
        end
      end
    end else begin
      if (!same) begin
        if (ent.iter != trip_dec) begin
          trained.conf = conf_dec;
          trained.trip = iter_inc;
        end
        trained.iter = '0;
      end else begin
        trained.iter = iter_inc;
        if (iter_inc >= ent.trip) begin
          trained.conf = conf_dec;
          trained.trip = '0;
          trained.iter = '0;
        end
      end
    end
  end

  // Build a fresh entry for a missed, mispredicted branch
  always_comb begin
    alloc       = '0;
    alloc.valid = 1'b1;
    alloc.tag   = tag_cmp;
    alloc.conf  = 2'd1;
    alloc.body  = cur_outcome;
  end

  assign rsv_write = hit || (saved_fallback != cur_outcome);

  // Write port: clearing pass or resolve write-back
  assign ram_we    = (state == ST_CLEAR) ||
                     ((state == ST_EXEC) && (cur_action == ACT_RESOLVE) && rsv_write);
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : saved_index;
  assign ram_wdata = (state == ST_CLEAR) ? entry_t'('0) : (hit ? trained : alloc);

  // Prediction for a predict word
  assign pred_use = hit && (ent.conf == CONF_MAX);
  assign pred_dir = pred_use ? ((iter_inc == ent.trip) ? ~ent.body : ent.body)
                             : saved_fallback;

  assign out_free  = !rsp_valid || rsp_ready;
  assign exec_done = (cur_action == ACT_RESOLVE) || out_free;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      saved_index    <= '0;
      saved_fallback <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
      // Remember index and fallback of each predict
      if (accept && (req_data.action == ACT_PREDICT)) begin
        saved_index    <= idx_pred;
        saved_fallback <= req_data.fallback_taken;
      end
      // Load or drain the response register
      if ((state == ST_EXEC) && (cur_action == ACT_PREDICT) && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Hold the accepted word and the response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_action  <= req_data.action;
      cur_tag     <= req_data.branch_tag;
      cur_outcome <= req_data.outcome_taken;
    end
    if ((state == ST_EXEC) && (cur_action == ACT_PREDICT) && out_free) begin
      rsp_data.predict_taken <= pred_dir;
      rsp_data.loop_used     <= pred_use;
    end
  end

  // Checks
  `LBP_ASSERT(a_no_pred_write, clk, rst, (ram_we && (state == ST_EXEC)) |-> (cur_action == ACT_RESOLVE), "predict wrote the table")
  `LBP_ASSERT(a_rw_apart, clk, rst, !(ram_we && ram_re), "table read and write in one cycle")
  `LBP_ASSERT(a_rsp_from_pred, clk, rst, $rose(rsp_valid) |-> $past((state == ST_EXEC) && (cur_action == ACT_PREDICT)), "response without a predict")
  `LBP_ASSERT(a_exec_after_accept, clk, rst, $rose(state == ST_EXEC) |-> $past(accept), "evaluation without an accepted word")
  `LBP_ASSERT(a_clear_blocks, clk, rst, (state == ST_CLEAR) |-> !req_ready, "request taken during clearing pass")

endmodule

@@ sv/lbp_ram.sv @@
// ----------------------------------------------------------------------------
// Loop branch predictor RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module lbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds its data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
